// File: src/sfoe_pkg.sv
// ----------------------------------------------------------------------------
// sfoe_pkg: shared types and constants of the simple glyph outline encoder
// Command record passed from the front queue to the back engine, and the
// default store sizes.
// ----------------------------------------------------------------------------
package sfoe_pkg;

  localparam int unsigned PT_CAP_DEF  = 1024;
  localparam int unsigned CTR_CAP_DEF = 256;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               curve_pt;
    logic               ends_contour;
    logic               last_point;
  } cmd_t;

endpackage

// File: src/sfoe_front.sv
// ----------------------------------------------------------------------------
// sfoe_front: command intake
// Accepts input items, classifies them as load or fetch commands and holds
// them in a two-entry queue for the back engine.
// ----------------------------------------------------------------------------
module sfoe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic signed [15:0] x_coord_i,
  input  logic signed [15:0] y_coord_i,
  input  logic               curve_pt_i,
  input  logic               ends_contour_i,
  input  logic               last_point_i,
  input  logic               pop_i,
  output logic               cmd_valid_o,
  output sfoe_pkg::cmd_t     cmd_o
);

  sfoe_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;
  sfoe_pkg::cmd_t cmd_in;

  assign busy        = (count_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    cmd_in.kind         = mode_i ? sfoe_pkg::CMD_FETCH : sfoe_pkg::CMD_LOAD;
    cmd_in.x_coord      = x_coord_i;
    cmd_in.y_coord      = y_coord_i;
    cmd_in.curve_pt     = curve_pt_i;
    cmd_in.ends_contour = ends_contour_i;
    cmd_in.last_point   = last_point_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: src/sfoe_back.sv
// ----------------------------------------------------------------------------
// sfoe_back: outline store and record emitter
// Executes load commands into the point and contour stores and walks the
// glyph record for fetch commands, one byte per fetch.
// ----------------------------------------------------------------------------
module sfoe_back #(
  parameter int unsigned PT_CAP  = sfoe_pkg::PT_CAP_DEF,
  parameter int unsigned CTR_CAP = sfoe_pkg::CTR_CAP_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sfoe_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o,
  output logic           no_data_o,
  output logic           overflow_error_o
);

  localparam int unsigned PW   = (PT_CAP > 1) ? $clog2(PT_CAP) : 1;
  localparam int unsigned PTW  = $clog2(PT_CAP + 1);
  localparam int unsigned CAW  = (CTR_CAP > 1) ? $clog2(CTR_CAP) : 1;
  localparam int unsigned CTW  = $clog2(CTR_CAP + 1);
  localparam int unsigned CUW0 = (PTW > CTW) ? PTW : CTW;
  localparam int unsigned CUW  = (CUW0 > 4) ? CUW0 : 4;
  localparam int unsigned RUN_W   = 9;
  localparam int unsigned RUN_MAX = 256;

  localparam logic [7:0] FLAG_ON      = 8'h01;
  localparam logic [7:0] FLAG_X_SHORT = 8'h02;
  localparam logic [7:0] FLAG_Y_SHORT = 8'h04;
  localparam logic [7:0] FLAG_REPEAT  = 8'h08;
  localparam logic [7:0] FLAG_X_SAME  = 8'h10;
  localparam logic [7:0] FLAG_Y_SAME  = 8'h20;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_ENDS   = 3'd2;
  localparam logic [2:0] PH_INSTR  = 3'd3;
  localparam logic [2:0] PH_FLAGS  = 3'd4;
  localparam logic [2:0] PH_XS     = 3'd5;
  localparam logic [2:0] PH_YS     = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ENDS  = 3'd1;
  localparam logic [2:0] ST_FLAG  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DELTA = 3'd4;
  localparam logic [2:0] ST_SKIP  = 3'd5;

  localparam logic [CUW-1:0] HDR_LAST   = CUW'(9);
  localparam logic [CUW-1:0] INSTR_LAST = CUW'(1);

  function automatic logic [7:0] axis_flag(input logic signed [16:0] d,
                                           input logic [7:0] short_bit,
                                           input logic [7:0] same_bit);
    logic [7:0] f;
    f = 8'h00;
    if (d == 17'sd0) begin
      f = same_bit;
    end else if (d > -17'sd256 && d < 17'sd256) begin
      f = short_bit | ((d > 17'sd0) ? same_bit : 8'h00);
    end
    return f;
  endfunction

  logic [7:0]     flag_mem [PT_CAP];
  logic [15:0]    xd_mem   [PT_CAP];
  logic [15:0]    yd_mem   [PT_CAP];
  logic [PW-1:0]  end_mem  [CTR_CAP];

  logic [7:0]     flag_rd_q;
  logic [15:0]    xd_rd_q, yd_rd_q;
  logic [PW-1:0]  end_rd_q;

  logic [2:0]       st_q, st_d;
  logic [2:0]       phase_q, phase_d;
  logic [CUW-1:0]   cursor_q, cursor_d;
  logic             half_q, half_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [7:0]       base_flag_q, base_flag_d;
  logic [PTW-1:0]   pt_q, pt_d;
  logic [CTW-1:0]   ct_q, ct_d;
  logic [15:0]      prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [15:0]      xmin_q, xmin_d, ymin_q, ymin_d, xmax_q, xmax_d, ymax_q, ymax_d;
  logic             empty_q, empty_d;
  logic             ready_q, ready_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_nodata_q, out_nodata_d;
  logic             out_ovf_q, out_ovf_d;

  logic             pt_we, end_we;
  logic [PW-1:0]    pt_wa;
  logic [CAW-1:0]   end_wa;
  logic [PW-1:0]    end_wd;
  logic [7:0]       flag_wd;
  logic [15:0]      xd_wd, yd_wd;
  logic [CUW-1:0]   rd_full;

  logic             clr;
  logic [PTW-1:0]   pt_e;
  logic [CTW-1:0]   ct_e;
  logic [15:0]      px_e, py_e;
  logic signed [16:0] dx, dy;
  logic [CUW-1:0]   pt_ext, ct_ext;
  logic [15:0]      ct16, e16, dsel;
  logic [7:0]       sbit, samebit, fcur;
  logic             nodata;
  logic             do_finish, do_settle;
  logic [RUN_W-1:0] fin_run;
  logic [7:0]       fin_flag;
  logic [CUW-1:0]   settle_cur, cur_n;

  assign pop_o            = (st_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_byte_o      = out_last_q;
  assign no_data_o        = out_nodata_q;
  assign overflow_error_o = out_ovf_q;

  assign pt_ext = CUW'(pt_q);
  assign ct_ext = CUW'(ct_q);
  assign ct16   = 16'(ct_q);
  assign e16    = 16'(end_rd_q);
  assign nodata = !ready_q || ovf_q || (pt_q == '0) || (ct_q == '0)
                  || (phase_q == PH_DONE) || (phase_q == PH_IDLE);
  assign sbit    = (phase_q == PH_XS) ? FLAG_X_SHORT : FLAG_Y_SHORT;
  assign samebit = (phase_q == PH_XS) ? FLAG_X_SAME : FLAG_Y_SAME;
  assign dsel    = (phase_q == PH_XS) ? xd_rd_q : yd_rd_q;

  always_comb begin
    clr  = ready_q;
    pt_e = clr ? '0 : pt_q;
    ct_e = clr ? '0 : ct_q;
    px_e = clr ? 16'h0000 : prev_x_q;
    py_e = clr ? 16'h0000 : prev_y_q;
    dx   = $signed({cmd_i.x_coord[15], cmd_i.x_coord}) - $signed({px_e[15], px_e});
    dy   = $signed({cmd_i.y_coord[15], cmd_i.y_coord}) - $signed({py_e[15], py_e});
    flag_wd = (cmd_i.curve_pt ? FLAG_ON : 8'h00)
              | axis_flag(dx, FLAG_X_SHORT, FLAG_X_SAME)
              | axis_flag(dy, FLAG_Y_SHORT, FLAG_Y_SAME);
    xd_wd  = dx[15:0];
    yd_wd  = dy[15:0];
    pt_wa  = pt_e[PW-1:0];
    end_wa = ct_e[CAW-1:0];
    end_wd = pt_e[PW-1:0];
  end

  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    cursor_d     = cursor_q;
    half_d       = half_q;
    run_d        = run_q;
    base_flag_d  = base_flag_q;
    pt_d         = pt_q;
    ct_d         = ct_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    xmin_d       = xmin_q;
    ymin_d       = ymin_q;
    xmax_d       = xmax_q;
    ymax_d       = ymax_q;
    empty_d      = empty_q;
    ready_d      = ready_q;
    ovf_d        = ovf_q;
    out_valid_d  = 1'b0;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_nodata_d = out_nodata_q;
    out_ovf_d    = out_ovf_q;
    pt_we        = 1'b0;
    end_we       = 1'b0;
    do_finish    = 1'b0;
    do_settle    = 1'b0;
    fin_run      = run_q;
    fin_flag     = base_flag_q;
    settle_cur   = cursor_q;
    cur_n        = cursor_q;
    fcur         = flag_rd_q;
    rd_full      = cursor_q;

    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == sfoe_pkg::CMD_LOAD) begin
            pt_d  = pt_e;
            ct_d  = ct_e;
            ovf_d = clr ? 1'b0 : ovf_q;
            if (pt_e < PTW'(PT_CAP)) begin
              pt_we = 1'b1;
              pt_d  = pt_e + PTW'(1);
              if (cmd_i.ends_contour) begin
                if (ct_e < CTW'(CTR_CAP)) begin
                  end_we = 1'b1;
                  ct_d   = ct_e + CTW'(1);
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end else begin
              ovf_d = 1'b1;
            end
            if (clr || empty_q) begin
              xmin_d = cmd_i.x_coord;
              xmax_d = cmd_i.x_coord;
              ymin_d = cmd_i.y_coord;
              ymax_d = cmd_i.y_coord;
            end else begin
              if (cmd_i.x_coord < $signed(xmin_q)) xmin_d = cmd_i.x_coord;
              if (cmd_i.y_coord < $signed(ymin_q)) ymin_d = cmd_i.y_coord;
              if (cmd_i.x_coord > $signed(xmax_q)) xmax_d = cmd_i.x_coord;
              if (cmd_i.y_coord > $signed(ymax_q)) ymax_d = cmd_i.y_coord;
            end
            empty_d  = 1'b0;
            prev_x_d = cmd_i.x_coord;
            prev_y_d = cmd_i.y_coord;
            ready_d  = cmd_i.last_point;
            if (cmd_i.last_point) begin
              phase_d  = PH_HEADER;
              cursor_d = '0;
              half_d   = 1'b0;
            end else if (clr) begin
              phase_d  = PH_IDLE;
              cursor_d = '0;
              half_d   = 1'b0;
            end
          end else if (nodata) begin
            out_valid_d  = 1'b1;
            out_byte_d   = 8'h00;
            out_last_d   = 1'b0;
            out_nodata_d = 1'b1;
            out_ovf_d    = ovf_q;
          end else begin
            out_last_d   = 1'b0;
            out_nodata_d = 1'b0;
            out_ovf_d    = ovf_q;
            case (phase_q)
              PH_HEADER: begin
                case (cursor_q[3:0])
                  4'd0:    out_byte_d = ct16[15:8];
                  4'd1:    out_byte_d = ct16[7:0];
                  4'd2:    out_byte_d = xmin_q[15:8];
                  4'd3:    out_byte_d = xmin_q[7:0];
                  4'd4:    out_byte_d = ymin_q[15:8];
                  4'd5:    out_byte_d = ymin_q[7:0];
                  4'd6:    out_byte_d = xmax_q[15:8];
                  4'd7:    out_byte_d = xmax_q[7:0];
                  4'd8:    out_byte_d = ymax_q[15:8];
                  4'd9:    out_byte_d = ymax_q[7:0];
                  default: out_byte_d = 8'h00;
                endcase
                out_valid_d = 1'b1;
                cursor_d    = cursor_q + CUW'(1);
                if (cursor_q == HDR_LAST) begin
                  phase_d  = PH_ENDS;
                  cursor_d = '0;
                  half_d   = 1'b0;
                end
              end
              PH_ENDS: st_d = ST_ENDS;
              PH_INSTR: begin
                out_byte_d  = 8'h00;
                out_valid_d = 1'b1;
                cursor_d    = cursor_q + CUW'(1);
                if (cursor_q == INSTR_LAST) begin
                  phase_d  = PH_FLAGS;
                  cursor_d = '0;
                  half_d   = 1'b0;
                end
              end
              PH_FLAGS: begin
                if (half_q) begin
                  out_byte_d = 8'(run_q - RUN_W'(1));
                  half_d     = 1'b0;
                  cur_n      = cursor_q + CUW'(run_q);
                  if (cur_n == pt_ext) begin
                    phase_d  = PH_XS;
                    cursor_d = '0;
                    st_d     = ST_SKIP;
                  end else begin
                    cursor_d    = cur_n;
                    out_valid_d = 1'b1;
                  end
                end else begin
                  st_d = ST_FLAG;
                end
              end
              PH_XS, PH_YS: st_d = ST_DELTA;
              default: st_d = ST_IDLE;
            endcase
          end
        end
      end
      ST_ENDS: begin
        out_valid_d = 1'b1;
        st_d        = ST_IDLE;
        if (!half_q) begin
          out_byte_d = e16[15:8];
          half_d     = 1'b1;
        end else begin
          out_byte_d = e16[7:0];
          half_d     = 1'b0;
          cursor_d   = cursor_q + CUW'(1);
          if (cursor_q + CUW'(1) == ct_ext) begin
            phase_d  = PH_INSTR;
            cursor_d = '0;
          end
        end
      end
      ST_FLAG: begin
        base_flag_d = flag_rd_q;
        run_d       = RUN_W'(1);
        if (cursor_q + CUW'(1) < pt_ext) begin
          st_d    = ST_RUN;
          rd_full = cursor_q + CUW'(1);
        end else begin
          do_finish = 1'b1;
          fin_run   = RUN_W'(1);
          fin_flag  = flag_rd_q;
        end
      end
      ST_RUN: begin
        fin_flag = base_flag_q;
        if (flag_rd_q == base_flag_q) begin
          run_d = run_q + RUN_W'(1);
          if ((cursor_q + CUW'(run_d) < pt_ext) && (run_d < RUN_W'(RUN_MAX))) begin
            rd_full = cursor_q + CUW'(run_d);
          end else begin
            do_finish = 1'b1;
            fin_run   = run_d;
          end
        end else begin
          do_finish = 1'b1;
          fin_run   = run_q;
        end
      end
      ST_DELTA: begin
        if ((fcur & sbit) != 8'h00) begin
          out_byte_d = dsel[15] ? (8'h00 - dsel[7:0]) : dsel[7:0];
          do_settle  = 1'b1;
          settle_cur = cursor_q + CUW'(1);
        end else if (!half_q) begin
          out_byte_d  = dsel[15:8];
          half_d      = 1'b1;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end else begin
          out_byte_d = dsel[7:0];
          half_d     = 1'b0;
          do_settle  = 1'b1;
          settle_cur = cursor_q + CUW'(1);
        end
      end
      ST_SKIP: begin
        if (((fcur & sbit) == 8'h00) && ((fcur & samebit) != 8'h00)) begin
          do_settle  = 1'b1;
          settle_cur = cursor_q + CUW'(1);
        end else begin
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (do_finish) begin
      st_d = ST_IDLE;
      if (fin_run == RUN_W'(1)) begin
        out_byte_d = fin_flag;
        run_d      = fin_run;
        if (cursor_q + CUW'(1) == pt_ext) begin
          phase_d  = PH_XS;
          cursor_d = '0;
          half_d   = 1'b0;
          st_d     = ST_SKIP;
        end else begin
          cursor_d    = cursor_q + CUW'(1);
          out_valid_d = 1'b1;
        end
      end else begin
        out_byte_d  = fin_flag | FLAG_REPEAT;
        half_d      = 1'b1;
        run_d       = fin_run;
        out_valid_d = 1'b1;
      end
    end

    if (do_settle) begin
      if (settle_cur == pt_ext) begin
        cursor_d = '0;
        half_d   = 1'b0;
        if (phase_q == PH_XS) begin
          phase_d = PH_YS;
          st_d    = ST_SKIP;
        end else begin
          phase_d     = PH_DONE;
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          st_d        = ST_IDLE;
        end
      end else begin
        cursor_d = settle_cur;
        st_d     = ST_SKIP;
      end
    end

    if (st_q != ST_RUN && !(st_q == ST_FLAG && st_d == ST_RUN)) begin
      rd_full = cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      flag_mem[pt_wa] <= flag_wd;
      xd_mem[pt_wa]   <= xd_wd;
      yd_mem[pt_wa]   <= yd_wd;
    end
    if (end_we) begin
      end_mem[end_wa] <= end_wd;
    end
    flag_rd_q <= flag_mem[rd_full[PW-1:0]];
    xd_rd_q   <= xd_mem[rd_full[PW-1:0]];
    yd_rd_q   <= yd_mem[rd_full[PW-1:0]];
    end_rd_q  <= end_mem[rd_full[CAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      phase_q      <= PH_IDLE;
      cursor_q     <= '0;
      half_q       <= 1'b0;
      run_q        <= RUN_W'(1);
      pt_q         <= '0;
      ct_q         <= '0;
      prev_x_q     <= 16'h0000;
      prev_y_q     <= 16'h0000;
      xmin_q       <= 16'h0000;
      ymin_q       <= 16'h0000;
      xmax_q       <= 16'h0000;
      ymax_q       <= 16'h0000;
      empty_q      <= 1'b1;
      ready_q      <= 1'b0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_nodata_q <= 1'b0;
      out_ovf_q    <= 1'b0;
    end else begin
      st_q         <= st_d;
      phase_q      <= phase_d;
      cursor_q     <= cursor_d;
      half_q       <= half_d;
      run_q        <= run_d;
      pt_q         <= pt_d;
      ct_q         <= ct_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      xmin_q       <= xmin_d;
      ymin_q       <= ymin_d;
      xmax_q       <= xmax_d;
      ymax_q       <= ymax_d;
      empty_q      <= empty_d;
      ready_q      <= ready_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      out_nodata_q <= out_nodata_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_flag_q <= base_flag_d;
    out_byte_q  <= out_byte_d;
  end

endmodule

// File: src/simple_glyph_outline_encoder.sv
// ----------------------------------------------------------------------------
// simple_glyph_outline_encoder: simple glyph record builder
// Loads outline points and reads back the packed simple-glyph record.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start with mode_i and the point fields; the item is taken on a
//   clock edge where start is high and busy is low. A two-entry command
//   queue sits in front of the engine, so busy rises only when it is full.
//   mode_i = 0 loads one point (no result). mode_i = 1 fetches one record
//   byte: out_valid_o pulses for one cycle with out_byte_o, last_byte_o,
//   no_data_o and overflow_error_o. The receiver cannot stall.
// Timing:
//   A load is taken straight from the engine's idle state. A fetch from
//   the header or instruction length returns in the cycle after it leaves
//   the queue, as does a pending repeat count that does not end the flags;
//   contour ends and deltas add a memory read state. A flag byte scans the
//   run of equal flags one store read per cycle, and delta bytes walk over
//   skipped points one read per cycle. The stores share one read address.
// Reset:
//   Clears counts, box, queue and emission state; stores are not cleared.
// ----------------------------------------------------------------------------
module simple_glyph_outline_encoder #(
  parameter int unsigned PT_CAP  = sfoe_pkg::PT_CAP_DEF,
  parameter int unsigned CTR_CAP = sfoe_pkg::CTR_CAP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic signed [15:0] x_coord_i,
  input  logic signed [15:0] y_coord_i,
  input  logic               curve_pt_i,
  input  logic               ends_contour_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o,
  output logic               no_data_o,
  output logic               overflow_error_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  sfoe_pkg::cmd_t cmd;

  sfoe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .curve_pt_i     (curve_pt_i),
    .ends_contour_i (ends_contour_i),
    .last_point_i   (last_point_i),
    .pop_i          (cmd_pop),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  sfoe_back #(
    .PT_CAP  (PT_CAP),
    .CTR_CAP (CTR_CAP)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .pop_o            (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .last_byte_o      (last_byte_o),
    .no_data_o        (no_data_o),
    .overflow_error_o (overflow_error_o)
  );

endmodule

// File: src/sfoe_checker.sv
// ----------------------------------------------------------------------------
// sfoe_checker: port-level checks
// Watches the result port of the glyph encoder for inconsistent records.
// ----------------------------------------------------------------------------
module sfoe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic [7:0] out_byte_o,
  input logic       last_byte_o,
  input logic       no_data_o,
  input logic       overflow_error_o
);

  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_data_o |-> out_byte_o == 8'h00 && !last_byte_o)
    else $error("no-data result carries payload");

  a_ovf_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_error_o |-> no_data_o)
    else $error("overflowed glyph returned data");

  a_last_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> !no_data_o)
    else $error("last byte flagged without data");

  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o && last_byte_o) |-> no_data_o)
    else $error("data returned after final byte");

endmodule

bind simple_glyph_outline_encoder sfoe_checker u_sfoe_checker (.*);
